>>> sv/cfw_pkg.sv
package cfw_pkg;

    // Default table size
    localparam int CFW_TABLE_DEPTH = 128;

    // Frame layout
    localparam logic [3:0] FRAME_LEN = 4'd12;
    localparam logic [3:0] LAST_POS  = 4'd11;
    localparam logic [3:0] ID_FIRST  = 4'd7;
    localparam logic [3:0] STAT_POS  = 4'd4;
    localparam logic [3:0] HDR_LEN   = 4'd4;

    // Result codes
    localparam logic [2:0] ST_BAD_SUM  = 3'd0;
    localparam logic [2:0] ST_NO_CARD  = 3'd1;
    localparam logic [2:0] ST_BAD_HDR  = 3'd2;
    localparam logic [2:0] ST_ENROLLED = 3'd3;
    localparam logic [2:0] ST_KNOWN    = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic byte_accept;
        logic scan_start;
        logic scan_run;
        logic finish_load;
    } cfw_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic frame_final;
        logic frame_good;
        logic scan_done;
        logic out_free;
    } cfw_status_t;

    // Expected header byte for positions 0 to 3
    function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = 8'h04;
            2'd1:    b = 8'h0C;
            2'd2:    b = 8'h02;
            default: b = 8'h20;
        endcase
        return b;
    endfunction

endpackage

>>> sv/cfw_ctrl.sv
module cfw_ctrl
    import cfw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  cfw_status_t status,
    output cfw_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready        = 1'b1;
                cmd.byte_accept = in_valid;
                if (in_valid && status.frame_final)
                begin
                    if (status.frame_good)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/cfw_datapath.sv
module cfw_datapath
    import cfw_pkg::*;
#(
    parameter int TABLE_DEPTH = CFW_TABLE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [7:0]  cfg_data,
    input  logic [7:0]  rx_byte,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  frame_status,
    output logic [31:0] card_id,
    output logic [7:0]  stored_count,
    input  cfw_cmd_t    cmd,
    output cfw_status_t status
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [7:0]    cfg_reg;
    logic [3:0]    pos_reg, pos_next;
    logic [7:0]    xor_reg, xor_next;
    logic          ok_reg, ok_next;
    logic          hdr_bad_reg, hdr_bad_next;
    logic [31:0]   id_reg, id_next;
    logic [2:0]    pre_status_reg, pre_status_next;
    logic          good_reg, good_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          cmp_pend_reg, cmp_pend_next;
    logic          found_reg, found_next;
    logic [31:0]   rd_data_reg;
    logic          out_valid_reg, out_valid_next;
    logic [2:0]    status_reg, status_next;
    logic [31:0]   card_id_reg, card_id_next;
    logic [7:0]    stored_reg, stored_next;

    logic [31:0]   card_mem [TABLE_DEPTH];

    logic [3:0]    pos_eff;
    logic          frame_active;
    logic          mem_re;
    logic          mem_we;
    logic          hit_now;
    logic          enroll_ok;

    // Byte position seen by the incoming byte
    assign pos_eff      = frame_start ? 4'd0 : pos_reg;
    assign frame_active = (cfg_reg != 8'd0) && (pos_eff < FRAME_LEN);

    // Scan compare, one entry per cycle behind the registered read
    assign hit_now   = cmp_pend_reg && (rd_data_reg == id_reg);
    assign mem_re    = cmd.scan_run && (scan_idx_reg < count_reg) && !hit_now;
    assign enroll_ok = (32'(count_reg) < 32'(cfg_reg)) &&
                       (32'(count_reg) < 32'(TABLE_DEPTH));
    assign mem_we    = cmd.finish_load && good_reg && !found_reg && enroll_ok;

    assign status.frame_final = frame_active && (pos_eff == LAST_POS);
    assign status.frame_good  = ((~xor_reg) == rx_byte) && ok_reg;
    assign status.scan_done   = hit_now || ((scan_idx_reg >= count_reg) && !cmp_pend_reg);
    assign status.out_free    = !out_valid_reg || out_ready;

    // Frame parsing, scan bookkeeping and result assembly
    always_comb
    begin
        pos_next        = pos_reg;
        xor_next        = xor_reg;
        ok_next         = ok_reg;
        hdr_bad_next    = hdr_bad_reg;
        id_next         = id_reg;
        pre_status_next = pre_status_reg;
        good_next       = good_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_pend_next   = cmp_pend_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        card_id_next    = card_id_reg;
        stored_next     = stored_reg;

        if (cmd.byte_accept && frame_active)
        begin
            // start flag restarts the frame
            if (frame_start)
            begin
                xor_next     = 8'd0;
                ok_next      = 1'b1;
                hdr_bad_next = 1'b0;
                id_next      = 32'd0;
            end
            pos_next = pos_eff + 4'd1;
            if (pos_eff < LAST_POS)
            begin
                xor_next = xor_next ^ rx_byte;
                if ((pos_eff < HDR_LEN) && (rx_byte != hdr_byte(pos_eff[1:0])))
                begin
                    ok_next      = 1'b0;
                    hdr_bad_next = 1'b1;
                end
                if ((pos_eff == STAT_POS) && (rx_byte != 8'd0))
                begin
                    ok_next = 1'b0;
                end
                if (pos_eff >= ID_FIRST)
                begin
                    id_next = {id_next[23:0], rx_byte};
                end
            end
            else
            begin
                // last byte: checksum, then header, then status
                good_next = 1'b0;
                if ((~xor_reg) != rx_byte)
                begin
                    pre_status_next = ST_BAD_SUM;
                end
                else if (!ok_reg && !hdr_bad_reg)
                begin
                    pre_status_next = ST_NO_CARD;
                end
                else if (!ok_reg)
                begin
                    pre_status_next = ST_BAD_HDR;
                end
                else
                begin
                    good_next = 1'b1;
                end
            end
        end

        if (cmd.scan_start)
        begin
            scan_idx_next = '0;
            cmp_pend_next = 1'b0;
            found_next    = 1'b0;
        end

        if (cmd.scan_run)
        begin
            cmp_pend_next = mem_re;
            if (mem_re)
            begin
                scan_idx_next = scan_idx_reg + CW'(1);
            end
            if (status.scan_done)
            begin
                found_next = hit_now;
            end
        end

        // Output register
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish_load)
        begin
            out_valid_next = 1'b1;
            card_id_next   = 32'd0;
            status_next    = pre_status_reg;
            if (good_reg)
            begin
                card_id_next = id_reg;
                if (found_reg)
                begin
                    status_next = ST_KNOWN;
                end
                else if (enroll_ok)
                begin
                    status_next = ST_ENROLLED;
                    count_next  = count_reg + CW'(1);
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            stored_next = 8'(count_next);
        end
    end

    // Control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= 8'd0;
            pos_reg        <= 4'd0;
            xor_reg        <= 8'd0;
            ok_reg         <= 1'b1;
            hdr_bad_reg    <= 1'b0;
            id_reg         <= 32'd0;
            good_reg       <= 1'b0;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            cmp_pend_reg   <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cfg_reg <= cfg_data;
            end
            pos_reg       <= pos_next;
            xor_reg       <= xor_next;
            ok_reg        <= ok_next;
            hdr_bad_reg   <= hdr_bad_next;
            id_reg        <= id_next;
            good_reg      <= good_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_pend_reg  <= cmp_pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pre_status_reg <= pre_status_next;
        status_reg     <= status_next;
        card_id_reg    <= card_id_next;
        stored_reg     <= stored_next;
    end

    // Card table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            card_mem[count_reg[AW-1:0]] <= id_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= card_mem[scan_idx_reg[AW-1:0]];
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_status = status_reg;
    assign card_id      = card_id_reg;
    assign stored_count = stored_reg;

endmodule

>>> sv/card_frame_check_and_whitelist_top.sv
// Card frame checker with a card ID whitelist.
// Input channel (in_valid/in_ready, rx_byte, frame_start) takes one reader
// byte per transaction; frame_start marks byte 0 of a 12-byte frame.
// Output channel (out_valid/out_ready) carries frame_status, card_id and
// stored_count, one transaction per completed frame (byte 11).
// Config channel (cfg_valid/cfg_ready, cfg_data) sets cards_to_enroll;
// write it only while the block is idle. Zero makes the block ignore bytes.
// Bytes 0 to 10 are taken while in_ready is high. Byte 11 of a bad frame
// leads straight to the result load; byte 11 of a good frame starts a scan
// over the stored cards through the single read port of the card memory,
// one entry per cycle, ending early on a hit. in_ready is low during the
// scan and result load.
// Reset clears the frame state, empties the table (fill count to zero) and
// sets cards_to_enroll to zero; no clearing pass is needed.
// A stalled receiver holds the result in the output register; further
// bytes are still taken, and the next frame result waits until the output
// register is free.
module card_frame_check_and_whitelist_top
    import cfw_pkg::*;
#(
    parameter int TABLE_DEPTH = CFW_TABLE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  frame_status,
    output logic [31:0] card_id,
    output logic [7:0]  stored_count
);

    cfw_cmd_t    cmd;
    cfw_status_t status;

    assign cfg_ready = 1'b1;

    cfw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cfw_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .rx_byte      (rx_byte),
        .frame_start  (frame_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_status (frame_status),
        .card_id      (card_id),
        .stored_count (stored_count),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

>>> sv/cfw_checker.sv
module cfw_checker
    import cfw_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  frame_status,
    input logic [31:0] card_id,
    input logic [7:0]  stored_count
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_status)
            && $stable(card_id) && $stable(stored_count))
        else $error("result changed while stalled");

    // Only defined result codes
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_status <= ST_FULL)
        else $error("undefined frame_status");

    // Rejected frames report no card number
    a_bad_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_status == ST_BAD_SUM || frame_status == ST_NO_CARD
            || frame_status == ST_BAD_HDR) |-> card_id == 32'd0)
        else $error("card_id set on rejected frame");

    // An enrolled card leaves the table non-empty
    a_enroll_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_status == ST_ENROLLED |-> stored_count != 8'd0)
        else $error("enrolled with empty table");

endmodule

bind card_frame_check_and_whitelist_top cfw_checker u_cfw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_status (frame_status),
    .card_id      (card_id),
    .stored_count (stored_count)
);

>>> test/tb_card_frame_check_and_whitelist_top.sv
`timescale 1ns / 1ps

module tb_card_frame_check_and_whitelist_top;
    import cfw_pkg::*;

    localparam int TABLE_DEPTH = CFW_TABLE_DEPTH;
    localparam logic [31:0] HDR_WORD = 32'h040C_0220;

    // One reader byte as the sender presents it
    typedef struct packed {
        logic [7:0] data;
        logic       sof;
    } reader_byte_t;

    // One frame verdict as the block reports it
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] id;
        logic [7:0]  count;
    } frame_verdict_t;

    // Shapes of generated frames
    typedef enum int {
        FK_GOOD,
        FK_BAD_SUM,
        FK_NO_CARD,
        FK_BAD_HDR,
        FK_HDR_AND_STAT,
        FK_CUT_SHORT,
        FK_TRAILING,
        FK_NOISE,
        FK_NO_SOF
    } frame_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'd0;
    logic        frame_start = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  frame_status;
    logic [31:0] card_id;
    logic [7:0]  stored_count;

    card_frame_check_and_whitelist_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .frame_start  (frame_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_status (frame_status),
        .card_id      (card_id),
        .stored_count (stored_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stimulus and expectation stores
    reader_byte_t   byte_q[$];
    frame_verdict_t verdict_q[$];
    logic [31:0]    used_ids[$];
    int unsigned    bytes_queued = 0;
    int unsigned    bytes_taken = 0;
    int unsigned    err_count = 0;

    // Shadow copy of the block state
    int unsigned    enroll_limit = 0;
    int unsigned    rx_pos = 0;
    logic [7:0]     rx_xor = 8'd0;
    logic           hdr_stat_ok = 1'b1;
    logic           hdr_wrong = 1'b0;
    logic [31:0]    rx_id = 32'd0;
    logic [31:0]    known_ids [TABLE_DEPTH];
    int unsigned    id_count = 0;

    task automatic report_mismatch(input string what);
        err_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Advance the shadow frame state by one accepted byte
    function automatic void track_reader_byte(input reader_byte_t rb);
        int unsigned    cap;
        logic           found;
        frame_verdict_t v;
        if (enroll_limit == 0)
            return;
        if (rb.sof)
        begin
            rx_pos      = 0;
            rx_xor      = 8'd0;
            hdr_stat_ok = 1'b1;
            hdr_wrong   = 1'b0;
            rx_id       = 32'd0;
        end
        if (rx_pos >= FRAME_LEN)
            return;
        if (rx_pos < LAST_POS)
        begin
            rx_xor = rx_xor ^ rb.data;
            if (rx_pos < HDR_LEN && rb.data != 8'(HDR_WORD >> (8 * (3 - rx_pos))))
            begin
                hdr_stat_ok = 1'b0;
                hdr_wrong   = 1'b1;
            end
            if (rx_pos == STAT_POS && rb.data != 8'd0)
                hdr_stat_ok = 1'b0;
            if (rx_pos >= ID_FIRST)
                rx_id = {rx_id[23:0], rb.data};
            rx_pos++;
            return;
        end
        rx_pos++;

        // Last byte: checksum, then header, then status byte, then table
        v.id = 32'd0;
        if (~rx_xor != rb.data)
            v.status = ST_BAD_SUM;
        else if (!hdr_stat_ok && !hdr_wrong)
            v.status = ST_NO_CARD;
        else if (!hdr_stat_ok)
            v.status = ST_BAD_HDR;
        else
        begin
            v.id  = rx_id;
            cap   = (enroll_limit > TABLE_DEPTH) ? TABLE_DEPTH : enroll_limit;
            found = 1'b0;
            for (int i = 0; i < id_count; i++)
            begin
                if (known_ids[i] == rx_id)
                    found = 1'b1;
            end
            if (found)
                v.status = ST_KNOWN;
            else if (id_count < cap)
            begin
                known_ids[id_count] = rx_id;
                id_count++;
                v.status = ST_ENROLLED;
            end
            else
                v.status = ST_FULL;
        end
        v.count = 8'(id_count);
        verdict_q.push_back(v);
    endfunction

    task automatic push_byte(input logic [7:0] data, input logic sof);
        reader_byte_t rb;
        rb.data = data;
        rb.sof  = sof;
        byte_q.push_back(rb);
        bytes_queued++;
    endtask

    // Build one frame of the given shape and queue its bytes
    task automatic queue_frame(input frame_kind_t kind, input logic [31:0] id);
        logic [7:0]  fb [12];
        logic [7:0]  x;
        int unsigned k;
        int unsigned cut;
        int unsigned extra;
        if (kind == FK_NOISE)
        begin
            extra = $urandom_range(1, 20);
            for (k = 0; k < extra; k++)
                push_byte(8'($urandom), $urandom_range(0, 7) == 0);
            return;
        end
        for (k = 0; k < 4; k++)
            fb[k] = 8'(HDR_WORD >> (8 * (3 - k)));
        fb[4]  = 8'd0;
        fb[5]  = 8'($urandom);
        fb[6]  = 8'($urandom);
        fb[7]  = id[31:24];
        fb[8]  = id[23:16];
        fb[9]  = id[15:8];
        fb[10] = id[7:0];
        if (kind == FK_NO_CARD || kind == FK_HDR_AND_STAT)
            fb[4] = 8'($urandom_range(1, 255));
        if (kind == FK_BAD_HDR || kind == FK_HDR_AND_STAT)
        begin
            k = $urandom_range(0, 3);
            fb[k] = fb[k] ^ 8'($urandom_range(1, 255));
        end
        x = 8'd0;
        for (k = 0; k < 11; k++)
            x = x ^ fb[k];
        fb[11] = ~x;
        if (kind == FK_BAD_SUM)
            fb[11] = fb[11] ^ 8'($urandom_range(1, 255));
        cut = (kind == FK_CUT_SHORT) ? $urandom_range(1, 11) : 12;
        for (k = 0; k < cut; k++)
            push_byte(fb[k], (k == 0) && (kind != FK_NO_SOF));
        if (kind == FK_TRAILING)
        begin
            extra = $urandom_range(1, 5);
            for (k = 0; k < extra; k++)
                push_byte(8'($urandom), 1'b0);
        end
    endtask

    // Random frame: mostly well formed, fresh or already seen card IDs
    task automatic queue_random_frame(input int unsigned good_pct, input int unsigned fresh_pct);
        logic [31:0] id;
        logic        fresh;
        frame_kind_t kind;
        if (used_ids.size() == 0 || $urandom_range(0, 99) < fresh_pct)
        begin
            id    = $urandom;
            fresh = 1'b1;
        end
        else
        begin
            id    = used_ids[$urandom_range(0, used_ids.size() - 1)];
            fresh = 1'b0;
        end
        if ($urandom_range(0, 99) < good_pct)
            kind = FK_GOOD;
        else
        begin
            case ($urandom_range(0, 7))
                0:       kind = FK_BAD_SUM;
                1:       kind = FK_NO_CARD;
                2:       kind = FK_BAD_HDR;
                3:       kind = FK_HDR_AND_STAT;
                4:       kind = FK_CUT_SHORT;
                5:       kind = FK_TRAILING;
                6:       kind = FK_NOISE;
                default: kind = FK_NO_SOF;
            endcase
        end
        if (kind == FK_GOOD && fresh)
            used_ids.push_back(id);
        queue_frame(kind, id);
    endtask

    // Register write, only issued while the block is idle
    task automatic write_limit(input logic [7:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        enroll_limit = value;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until every byte is taken and every verdict has arrived
    task automatic wait_drained();
        @(negedge clk);
        while (bytes_taken != bytes_queued || verdict_q.size() != 0)
            @(negedge clk);
        repeat (TABLE_DEPTH + 8) @(negedge clk);
    endtask

    // Byte driver: bursts with random gaps
    reader_byte_t drv_byte;
    reader_byte_t seen_byte;
    int unsigned  burst_left = 1;
    int unsigned  gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                seen_byte.data = rx_byte;
                seen_byte.sof  = frame_start;
                track_reader_byte(seen_byte);
                bytes_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (byte_q.size() != 0)
                begin
                    drv_byte = byte_q.pop_front();
                    in_valid    <= 1'b1;
                    rx_byte     <= drv_byte.data;
                    frame_start <= drv_byte.sof;
                    if (burst_left <= 1)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor with its own stall pattern
    frame_verdict_t want;
    int unsigned    ready_mode = 0;
    int unsigned    mode_left = 0;
    int unsigned    hold_left = 0;
    logic           hold_level = 1'b0;
    logic           next_ready;
    logic [1:0]     phase_cnt = 2'd0;

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch($sformatf("unexpected result status %0d id %h count %0d",
                                              frame_status, card_id, stored_count));
                else
                begin
                    want = verdict_q.pop_front();
                    if (frame_status != want.status || card_id != want.id ||
                        stored_count != want.count)
                        report_mismatch($sformatf(
                            "status %0d/%0d id %h/%h count %0d/%0d (got/expected)",
                            frame_status, want.status, card_id, want.id,
                            stored_count, want.count));
                end
            end
            // pick a new stall pattern now and then
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(50, 400);
            end
            else
                mode_left--;
            phase_cnt = phase_cnt + 2'd1;
            case (ready_mode)
                0: next_ready = 1'b1;
                1: next_ready = 1'($urandom_range(0, 1));
                2: next_ready = (phase_cnt == 2'd0);
                default:
                begin
                    if (hold_left == 0)
                    begin
                        hold_level = !hold_level;
                        hold_left  = hold_level ? $urandom_range(1, 8) : $urandom_range(1, 60);
                    end
                    else
                        hold_left--;
                    next_ready = hold_level;
                end
            endcase
            out_ready <= next_ready;
        end
    end

    // Main sequence
    initial
    begin
        int unsigned base;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Idle block: everything is ignored
        write_limit(8'd0);
        queue_frame(FK_GOOD, 32'h1234_5678);
        queue_frame(FK_NOISE, 32'd0);
        wait_drained();

        // Directed frames with room for one card
        write_limit(8'd1);
        queue_frame(FK_NO_SOF, 32'hFFFF_FFFF);
        queue_frame(FK_GOOD, 32'hFFFF_FFFF);
        queue_frame(FK_GOOD, 32'h0000_0000);
        queue_frame(FK_BAD_SUM, 32'h0000_0000);
        queue_frame(FK_NO_CARD, 32'hFFFF_FFFF);
        queue_frame(FK_BAD_HDR, 32'h0000_0000);
        queue_frame(FK_HDR_AND_STAT, 32'hFFFF_FFFF);
        queue_frame(FK_CUT_SHORT, 32'h0000_0000);
        queue_frame(FK_GOOD, 32'hFFFF_FFFF);
        queue_frame(FK_TRAILING, 32'hFFFF_FFFF);
        used_ids.push_back(32'hFFFF_FFFF);
        for (int i = 0; i < 5; i++)
            queue_random_frame(70, 50);
        wait_drained();

        write_limit(8'd3);
        for (int i = 0; i < 6; i++)
            queue_random_frame(70, 60);
        wait_drained();

        // Limit above the table: fill it to the top
        write_limit(8'd255);
        base = used_ids.size();
        while (used_ids.size() < base + 128)
            queue_random_frame(97, 99);
        wait_drained();

        // Limit below the stored count
        write_limit(8'd5);
        for (int i = 0; i < 6; i++)
            queue_random_frame(70, 40);
        wait_drained();

        write_limit(8'd128);
        for (int i = 0; i < 5; i++)
            queue_random_frame(70, 50);
        wait_drained();

        write_limit(8'd0);
        for (int i = 0; i < 2; i++)
            queue_random_frame(70, 50);
        wait_drained();

        write_limit(8'd200);
        for (int i = 0; i < 4; i++)
            queue_random_frame(70, 50);
        wait_drained();

        if (err_count == 0 && verdict_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
